// File: hdl/modular_exponentiation_macros.svh
// Assertion macros shared by the modular exponentiation checker.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Checked at every clock edge outside reset.
`define MEXP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/mexp_pkg.sv
// Shared constants and types of the modular exponentiation pipeline.
package mexp_pkg;

	localparam int MEXP_DEF_WIDTH = 12;

	// Control bits that travel with every transaction down the cell chain.
	typedef struct packed {
		logic valid;
		logic mod_zero;
	} mexp_ctl_t;

endpackage

// File: hdl/mexp_rem_cell.sv
// One restoring-remainder step: reduces the base modulo the modulus one bit per cell.
module mexp_rem_cell
	import mexp_pkg::*;
#(
	parameter int WIDTH   = MEXP_DEF_WIDTH,
	parameter int BIT_SEL = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  mexp_ctl_t        prev_ctl,
	input  logic [WIDTH-1:0] prev_rem,
	input  logic [WIDTH-1:0] prev_base,
	input  logic [WIDTH-1:0] prev_expo,
	input  logic [WIDTH-1:0] prev_mod,
	output mexp_ctl_t        next_ctl,
	output logic [WIDTH-1:0] next_rem,
	output logic [WIDTH-1:0] next_base,
	output logic [WIDTH-1:0] next_expo,
	output logic [WIDTH-1:0] next_mod
);

	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] rem_d;

	// Shift in one base bit, subtract the modulus if it fits
	assign shifted = {prev_rem, prev_base[BIT_SEL]};
	assign diff    = shifted - {1'b0, prev_mod};
	assign rem_d   = (shifted >= {1'b0, prev_mod}) ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ctl <= '0;
		end else if (en) begin
			next_ctl <= prev_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_rem  <= rem_d;
			next_base <= prev_base;
			next_expo <= prev_expo;
			next_mod  <= prev_mod;
		end
	end

endmodule

// File: hdl/mexp_mul_cell.sv
// One shift-and-add step of a modular product: double, then add the multiplicand on a set bit.
module mexp_mul_cell
	import mexp_pkg::*;
#(
	parameter int WIDTH   = MEXP_DEF_WIDTH,
	parameter int BIT_SEL = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mexp_ctl_t          prev_ctl,
	input  logic [WIDTH-1:0]   prev_a,
	input  logic [WIDTH-1:0]   prev_b,
	input  logic [WIDTH-1:0]   prev_acc,
	input  logic [WIDTH-1:0]   prev_mod,
	input  logic [2*WIDTH-1:0] prev_side,
	output mexp_ctl_t          next_ctl,
	output logic [WIDTH-1:0]   next_a,
	output logic [WIDTH-1:0]   next_b,
	output logic [WIDTH-1:0]   next_acc,
	output logic [WIDTH-1:0]   next_mod,
	output logic [2*WIDTH-1:0] next_side
);

	// (x + y) mod m for x, y < m, without leaving WIDTH bits
	function automatic logic [WIDTH-1:0] add_mod(
		input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y,
		input logic [WIDTH-1:0] m
	);
		logic [WIDTH-1:0] gap;
		gap = m - y;
		return (x >= gap) ? (x - gap) : (x + y);
	endfunction

	logic [WIDTH-1:0] dbl;
	logic [WIDTH-1:0] acc_d;

	assign dbl   = add_mod(prev_acc, prev_acc, prev_mod);
	assign acc_d = prev_b[BIT_SEL] ? add_mod(dbl, prev_a, prev_mod) : dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_ctl <= '0;
		end else if (en) begin
			next_ctl <= prev_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_a    <= prev_a;
			next_b    <= prev_b;
			next_acc  <= acc_d;
			next_mod  <= prev_mod;
			next_side <= prev_side;
		end
	end

endmodule

// File: hdl/modular_exponentiation.sv
// A transaction passes the base reduction cells, then the square-and-multiply cells, then the output register.
// Throughput: one transaction per cycle unless stalled; every cell of the chain is a pipeline stage.
// Each exponent bit costs 2*WIDTH cells: WIDTH for the square, WIDTH for the multiply.
// The whole chain holds while a result waits on a stalled output register.
// Reset clears all valid bits at once; no clearing pass.
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int WIDTH = MEXP_DEF_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] base_value,
	input  logic [WIDTH-1:0] exponent_value,
	input  logic [WIDTH-1:0] modulus_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] power_residue
);

	localparam int NMUL = 2 * WIDTH * WIDTH;

	logic en;
	logic out_valid_q;
	logic [WIDTH-1:0] residue_q;

	// Chain advances unless a finished result is held by the sink
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// Base reduction chain
	mexp_ctl_t        r_ctl  [WIDTH+1];
	logic [WIDTH-1:0] r_rem  [WIDTH+1];
	logic [WIDTH-1:0] r_base [WIDTH+1];
	logic [WIDTH-1:0] r_expo [WIDTH+1];
	logic [WIDTH-1:0] r_mod  [WIDTH+1];

	assign r_ctl[0]  = '{valid: in_valid, mod_zero: (modulus_value == '0)};
	assign r_rem[0]  = '0;
	assign r_base[0] = base_value;
	assign r_expo[0] = exponent_value;
	assign r_mod[0]  = modulus_value;

	for (genvar j = 0; j < WIDTH; j++) begin : g_rem
		mexp_rem_cell #(.WIDTH(WIDTH), .BIT_SEL(WIDTH - 1 - j)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.prev_ctl(r_ctl[j]), .prev_rem(r_rem[j]), .prev_base(r_base[j]),
			.prev_expo(r_expo[j]), .prev_mod(r_mod[j]),
			.next_ctl(r_ctl[j+1]), .next_rem(r_rem[j+1]), .next_base(r_base[j+1]),
			.next_expo(r_expo[j+1]), .next_mod(r_mod[j+1])
		);
	end

	// Square-and-multiply chain; side carries {exponent, reduced base}
	mexp_ctl_t          m_ctl  [NMUL+1];
	logic [WIDTH-1:0]   m_a    [NMUL+1];
	logic [WIDTH-1:0]   m_b    [NMUL+1];
	logic [WIDTH-1:0]   m_acc  [NMUL+1];
	logic [WIDTH-1:0]   m_mod  [NMUL+1];
	logic [2*WIDTH-1:0] m_side [NMUL+1];

	// Running power starts at 1 mod m
	assign m_ctl[0]  = r_ctl[WIDTH];
	assign m_a[0]    = (r_mod[WIDTH] == WIDTH'(1)) ? '0 : WIDTH'(1);
	assign m_b[0]    = '0;
	assign m_acc[0]  = '0;
	assign m_mod[0]  = r_mod[WIDTH];
	assign m_side[0] = {r_expo[WIDTH], r_rem[WIDTH]};

	for (genvar c = 0; c < NMUL; c++) begin : g_mul
		localparam int STEP  = c % WIDTH;
		localparam int PHASE = (c / WIDTH) % 2;
		localparam int EBIT  = c / (2 * WIDTH);

		logic [WIDTH-1:0] a_in;
		logic [WIDTH-1:0] b_in;
		logic [WIDTH-1:0] acc_in;

		if (STEP != 0) begin : g_pass
			assign a_in   = m_a[c];
			assign b_in   = m_b[c];
			assign acc_in = m_acc[c];
		end else if (PHASE == 0) begin : g_square
			logic [WIDTH-1:0] x_in;
			// Power so far: after the previous bit's multiply, keep product or square
			if (c == 0) begin : g_first
				assign x_in = m_a[c];
			end else begin : g_next
				assign x_in = m_side[c][2*WIDTH-EBIT] ? m_acc[c] : m_a[c];
			end
			assign a_in   = x_in;
			assign b_in   = x_in;
			assign acc_in = '0;
		end else begin : g_mult
			// Square stays in a; multiply it by the reduced base
			assign a_in   = m_acc[c];
			assign b_in   = m_side[c][WIDTH-1:0];
			assign acc_in = '0;
		end

		mexp_mul_cell #(.WIDTH(WIDTH), .BIT_SEL(WIDTH - 1 - STEP)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.prev_ctl(m_ctl[c]), .prev_a(a_in), .prev_b(b_in), .prev_acc(acc_in),
			.prev_mod(m_mod[c]), .prev_side(m_side[c]),
			.next_ctl(m_ctl[c+1]), .next_a(m_a[c+1]), .next_b(m_b[c+1]),
			.next_acc(m_acc[c+1]), .next_mod(m_mod[c+1]), .next_side(m_side[c+1])
		);
	end

	// Output register: a zero modulus gives zero, else the last exponent bit selects product or square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= m_ctl[NMUL].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (m_ctl[NMUL].mod_zero) begin
				residue_q <= '0;
			end else if (m_side[NMUL][WIDTH]) begin
				residue_q <= m_acc[NMUL];
			end else begin
				residue_q <= m_a[NMUL];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign power_residue = residue_q;

endmodule

// File: hdl/mexp_checker.sv
// Port-level checker for the modular exponentiation block, with its bind.
`include "modular_exponentiation_macros.svh"

module mexp_checker
	import mexp_pkg::*;
#(
	parameter int WIDTH = MEXP_DEF_WIDTH
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [WIDTH-1:0] power_residue
);

	// A held result stays put
	`MEXP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(power_residue), "result changed while stalled")
	// Input side stalls exactly when the output register is blocked
	`MEXP_ASSERT(a_stall_link, in_stall == (out_valid && out_stall), "input stall not tied to blocked output")
	// A residue is below the modulus, so it can never be all ones
	`MEXP_ASSERT(a_residue_range, out_valid |-> power_residue != '1, "residue out of range")
	// A cycle under reset leaves no result behind
	`MEXP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result valid after reset")

endmodule

bind modular_exponentiation mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);
